@@ src/dvt_pkg.sv @@
// Shared types and constants for the dispense valve tick timers.
// No dependencies.
package dvt_pkg;

	typedef enum logic [2:0] {
		ACT_TICK         = 3'd0,
		ACT_START_DISP   = 3'd1,
		ACT_LOAD_BEEP    = 3'd2,
		ACT_LOAD_MS      = 3'd3,
		ACT_LOAD_SOAK    = 3'd4,
		ACT_START_DELAY  = 3'd5,
		ACT_CLEAR_FLAGS  = 3'd6,
		ACT_CLEAR_SECS   = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		VALVE_OFF  = 2'd0,
		VALVE_HIGH = 2'd1,
		VALVE_HOLD = 2'd2
	} valve_t;

	localparam logic [5:0]  BOOST_TICKS     = 6'd45;
	localparam logic [3:0]  SUB_MS_RELOAD   = 4'd10;
	localparam logic [4:0]  KEY_RELOAD      = 5'd20;
	localparam logic [9:0]  BLINK_FIRST     = 10'd1000;
	localparam logic [9:0]  BLINK_RELOAD    = 10'd900;
	localparam logic [9:0]  BLINK_OFF_POINT = 10'd250;
	localparam logic [9:0]  SECOND_RELOAD   = 10'd1000;
	localparam logic [15:0] MAX16           = 16'hFFFF;
	localparam logic [15:0] PAUSE_RESET     = 16'd300;

	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 80;

	// Packed lowest field last, so valve_drive lands in bit 0.
	typedef struct packed {
		logic [15:0] pressure_seconds;
		logic [15:0] idle_seconds;
		logic        delay_done;
		logic [15:0] soak_seconds_left;
		logic [15:0] ms_timer_left;
		logic        second_flag;
		logic        blink_off_flag;
		logic        blink_on_flag;
		logic        key_scan_pulse;
		logic        beep_on;
		logic        dispensing;
		logic [1:0]  valve_drive;
	} result_t;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		return (|v[31:16]) ? MAX16 : v[15:0];
	endfunction

	function automatic logic [15:0] up_sat16(input logic [15:0] v);
		return (v == MAX16) ? MAX16 : v + 16'd1;
	endfunction

	function automatic logic [15:0] down16(input logic [15:0] v);
		return (v != 16'd0) ? v - 16'd1 : 16'd0;
	endfunction

endpackage

@@ src/dvt_timer_core.sv @@
// Timer state registers and the per-item update: valve sequence, ms prescaler,
// countdowns, blink/second flags. Depends on dvt_pkg.
module dvt_timer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data,
	input  logic              step_en,
	input  logic [2:0]        action,
	input  logic [31:0]       value,
	output dvt_pkg::result_t  result
);
	import dvt_pkg::*;

	logic [15:0] pause_cfg_val_q;
	logic        active_q, active_d;
	logic [31:0] dticks_q, dticks_d;
	logic [5:0]  boost_q, boost_d;
	logic [15:0] pause_q, pause_d;
	logic [1:0]  valve_q, valve_d;
	logic [3:0]  sub_ms_q, sub_ms_d;
	logic [4:0]  key_pre_q, key_pre_d;
	logic [9:0]  blink_pre_q, blink_pre_d;
	logic [9:0]  sec_pre_q, sec_pre_d;
	logic [9:0]  soak_pre_q, soak_pre_d;
	logic [15:0] beep_q, beep_d;
	logic [15:0] ms_cnt_q, ms_cnt_d;
	logic [15:0] soak_q, soak_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [15:0] target_q, target_d;
	logic [15:0] idle_q, idle_d;
	logic [15:0] press_q, press_d;
	logic [2:0]  flags_q, flags_d;
	logic        strobe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_cfg_val_q <= PAUSE_RESET;
		end else if (cfg_wr_en) begin
			pause_cfg_val_q <= cfg_wr_data;
		end
	end

	always_comb begin
		active_d    = active_q;
		dticks_d    = dticks_q;
		boost_d     = boost_q;
		pause_d     = pause_q;
		valve_d     = valve_q;
		sub_ms_d    = sub_ms_q;
		key_pre_d   = key_pre_q;
		blink_pre_d = blink_pre_q;
		sec_pre_d   = sec_pre_q;
		soak_pre_d  = soak_pre_q;
		beep_d      = beep_q;
		ms_cnt_d    = ms_cnt_q;
		soak_d      = soak_q;
		elapsed_d   = elapsed_q;
		target_d    = target_q;
		idle_d      = idle_q;
		press_d     = press_q;
		flags_d     = flags_q;
		strobe      = 1'b0;

		case (action)
			ACT_TICK: begin
				if (active_q && pause_q == 16'd0) begin
					if (boost_q != 6'd0) begin
						if (boost_q >= BOOST_TICKS)
							valve_d = VALVE_HIGH;
						else if (boost_q == 6'd1)
							valve_d = VALVE_HOLD;
						boost_d = boost_q - 6'd1;
					end
					dticks_d = dticks_q - 32'd1;
					if (dticks_d == 32'd0) begin
						valve_d  = VALVE_OFF;
						active_d = 1'b0;
						boost_d  = BOOST_TICKS;
						pause_d  = pause_cfg_val_q;
					end
				end
				sub_ms_d = (sub_ms_q != 4'd0) ? sub_ms_q - 4'd1 : 4'd0;
				if (sub_ms_d == 4'd0) begin
					sub_ms_d  = SUB_MS_RELOAD;
					ms_cnt_d  = down16(ms_cnt_q);
					pause_d   = down16(pause_d);
					beep_d    = down16(beep_q);
					elapsed_d = up_sat16(elapsed_q);

					key_pre_d = (key_pre_q != 5'd0) ? key_pre_q - 5'd1 : 5'd0;
					if (key_pre_d == 5'd0) begin
						key_pre_d = KEY_RELOAD;
						strobe    = 1'b1;
					end

					blink_pre_d = (blink_pre_q != 10'd0) ? blink_pre_q - 10'd1 : 10'd0;
					if (blink_pre_d == 10'd0) begin
						blink_pre_d = BLINK_RELOAD;
						flags_d[0]  = 1'b1;
					end else if (blink_pre_d == BLINK_OFF_POINT) begin
						flags_d[1] = 1'b1;
					end

					sec_pre_d = (sec_pre_q != 10'd0) ? sec_pre_q - 10'd1 : 10'd0;
					if (sec_pre_d == 10'd0) begin
						sec_pre_d = SECOND_RELOAD;
						idle_d    = up_sat16(idle_q);
						press_d   = up_sat16(press_q);
					end

					if (soak_q != 16'd0) begin
						soak_pre_d = (soak_pre_q != 10'd0) ? soak_pre_q - 10'd1 : 10'd0;
						if (soak_pre_d == 10'd0) begin
							soak_pre_d = SECOND_RELOAD;
							soak_d     = soak_q - 16'd1;
							flags_d[2] = 1'b1;
						end
					end
				end
			end
			ACT_START_DISP: begin
				if (value != 32'd0) begin
					dticks_d = value;
					active_d = 1'b1;
				end
			end
			ACT_LOAD_BEEP:  beep_d   = sat16(value);
			ACT_LOAD_MS:    ms_cnt_d = sat16(value);
			ACT_LOAD_SOAK:  soak_d   = sat16(value);
			ACT_START_DELAY: begin
				target_d  = sat16(value);
				elapsed_d = 16'd0;
			end
			ACT_CLEAR_FLAGS: flags_d = 3'b000;
			ACT_CLEAR_SECS: begin
				idle_d  = 16'd0;
				press_d = 16'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			dticks_q    <= 32'd0;
			boost_q     <= BOOST_TICKS;
			pause_q     <= 16'd0;
			valve_q     <= VALVE_OFF;
			sub_ms_q    <= SUB_MS_RELOAD;
			key_pre_q   <= KEY_RELOAD;
			blink_pre_q <= BLINK_FIRST;
			sec_pre_q   <= SECOND_RELOAD;
			soak_pre_q  <= SECOND_RELOAD;
			beep_q      <= 16'd0;
			ms_cnt_q    <= 16'd0;
			soak_q      <= 16'd0;
			elapsed_q   <= 16'd0;
			target_q    <= 16'd0;
			idle_q      <= 16'd0;
			press_q     <= 16'd0;
			flags_q     <= 3'b000;
		end else if (step_en) begin
			active_q    <= active_d;
			dticks_q    <= dticks_d;
			boost_q     <= boost_d;
			pause_q     <= pause_d;
			valve_q     <= valve_d;
			sub_ms_q    <= sub_ms_d;
			key_pre_q   <= key_pre_d;
			blink_pre_q <= blink_pre_d;
			sec_pre_q   <= sec_pre_d;
			soak_pre_q  <= soak_pre_d;
			beep_q      <= beep_d;
			ms_cnt_q    <= ms_cnt_d;
			soak_q      <= soak_d;
			elapsed_q   <= elapsed_d;
			target_q    <= target_d;
			idle_q      <= idle_d;
			press_q     <= press_d;
			flags_q     <= flags_d;
		end
	end

	always_comb begin
		result.valve_drive       = valve_d;
		result.dispensing        = active_d;
		result.beep_on           = (beep_d != 16'd0);
		result.key_scan_pulse    = strobe;
		result.blink_on_flag     = flags_d[0];
		result.blink_off_flag    = flags_d[1];
		result.second_flag       = flags_d[2];
		result.ms_timer_left     = ms_cnt_d;
		result.soak_seconds_left = soak_d;
		result.delay_done        = (elapsed_d >= target_d);
		result.idle_seconds      = idle_d;
		result.pressure_seconds  = press_d;
	end

	a_valve_off_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> valve_q == VALVE_OFF)
		else $error("valve driven with no dispense active");

	a_boost_range: assert property (@(posedge clk) disable iff (!arst_n)
		boost_q <= BOOST_TICKS)
		else $error("boost counter above reload");

	a_sub_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_ms_q != 4'd0 && sub_ms_q <= SUB_MS_RELOAD)
		else $error("sub-ms prescaler out of range");

	a_active_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> dticks_q != 32'd0)
		else $error("dispense active with zero ticks left");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr_en |=> $stable(pause_cfg_val_q))
		else $error("pause register changed without a write");

endmodule

@@ src/dispense_valve_tick_timers.sv @@
// Top level of the dispense valve tick timers: input register, timer core,
// output register. Depends on dvt_pkg and dvt_timer_core.
//
// Usage:
//   Slave channel s_*: one item per command; s_tuser carries the action
//   (0 tick of 100 us, 1 start dispense, 2 load beep, 3 load ms timer,
//   4 load soak, 5 start delay, 6 clear flags, 7 clear second counters),
//   s_tdata the 32-bit operand.
//   Master channel m_*: one result item per input item, the timer state
//   right after that item.
//   cfg_wr_en/cfg_wr_data write the post-dispense pause in ms (reset 300);
//   write only while no item is in flight.
//   m_tvalid rises once an accepted item has passed the input register and
//   then the output register. Throughput: one item per cycle while m_tready
//   is high; the input register and the output register each hold one
//   item, and the state update is combinational logic between them.
//   When m_tready is low the output register holds, the input register
//   still fills, and s_tready drops only once both are full.
//   Reset (arst_n low) clears all counters to their power-up values,
//   empties both registers, and restores the pause register to 300.
module dispense_valve_tick_timers (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [15:0]                     cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dvt_pkg::IN_DATA_W-1:0]   s_tdata,  // value[31:0]
	input  logic [dvt_pkg::IN_USER_W-1:0]   s_tuser,  // action[2:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// valve_drive[1:0], dispensing[2], beep_on[3], key_scan_pulse[4],
	// blink_on_flag[5], blink_off_flag[6], second_flag[7], ms_timer_left[23:8],
	// soak_seconds_left[39:24], delay_done[40], idle_seconds[56:41],
	// pressure_seconds[72:57], zero[79:73]
	output logic [dvt_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import dvt_pkg::*;

	logic        valid_s1;
	logic [2:0]  action_s1;
	logic [31:0] value_s1;
	logic        m_valid_q;
	result_t     result;
	result_t     result_q;
	logic        advance;
	logic        step_en;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			value_s1  <= s_tdata;
		end
	end

	dvt_timer_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (step_en),
		.action      (action_s1),
		.value       (value_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step_en) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			result_q <= result;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_q};

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_valid_q && !m_tready |-> !s_tready)
		else $error("input taken while both registers are full");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |=> m_valid_q && $stable(result_q))
		else $error("stalled result lost or changed");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> m_valid_q)
		else $error("processed item did not reach the output register");

endmodule

@@ bench/dvt_timer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the dispense valve tick timers: watches the config port and both
// stream channels, predicts every result item and compares it field by field.
// Depends on dvt_pkg.
module dvt_timer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [15:0]                    cfg_wr_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [dvt_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [dvt_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [dvt_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                             errors,
	output int                             outstanding
);
	import dvt_pkg::*;

	localparam int RES_W = $bits(result_t);

	logic        disp_on;
	logic [31:0] disp_left;
	logic [5:0]  boost_left;
	logic [15:0] pause_cfg;
	logic [15:0] pause_left;
	valve_t      valve;
	logic [3:0]  tick_div;
	logic [4:0]  key_div;
	logic [9:0]  blink_div;
	logic [9:0]  sec_div;
	logic [9:0]  soak_div;
	logic [15:0] beep_ms;
	logic [15:0] ms_left;
	logic [15:0] soak_left;
	logic [15:0] elapsed_ms;
	logic [15:0] delay_goal;
	logic [15:0] idle_s;
	logic [15:0] press_s;
	logic        flag_on;
	logic        flag_off;
	logic        flag_sec;

	result_t status_due[$];
	result_t got;
	result_t want;
	string   diff;
	int      err_count;

	function automatic result_t step_timers(input action_t act, input logic [31:0] val);
		logic [15:0] clipped;
		logic        strobe;
		result_t     r;
		clipped = (|val[31:16]) ? 16'hFFFF : val[15:0];
		strobe = 1'b0;
		case (act)
			ACT_TICK: begin
				if (disp_on && pause_left == 16'd0) begin
					if (boost_left != 6'd0) begin
						if (boost_left >= BOOST_TICKS)
							valve = VALVE_HIGH;
						else if (boost_left == 6'd1)
							valve = VALVE_HOLD;
						boost_left = boost_left - 6'd1;
					end
					disp_left = disp_left - 32'd1;
					if (disp_left == 32'd0) begin
						valve = VALVE_OFF;
						disp_on = 1'b0;
						boost_left = BOOST_TICKS;
						pause_left = pause_cfg;
					end
				end
				if (tick_div != 4'd0)
					tick_div = tick_div - 4'd1;
				if (tick_div == 4'd0) begin
					// one millisecond elapsed
					tick_div = SUB_MS_RELOAD;
					ms_left = (ms_left != 16'd0) ? ms_left - 16'd1 : 16'd0;
					pause_left = (pause_left != 16'd0) ? pause_left - 16'd1 : 16'd0;
					beep_ms = (beep_ms != 16'd0) ? beep_ms - 16'd1 : 16'd0;
					if (elapsed_ms != 16'hFFFF)
						elapsed_ms = elapsed_ms + 16'd1;
					if (key_div != 5'd0)
						key_div = key_div - 5'd1;
					if (key_div == 5'd0) begin
						key_div = KEY_RELOAD;
						strobe = 1'b1;
					end
					if (blink_div != 10'd0)
						blink_div = blink_div - 10'd1;
					if (blink_div == 10'd0) begin
						blink_div = BLINK_RELOAD;
						flag_on = 1'b1;
					end else if (blink_div == BLINK_OFF_POINT) begin
						flag_off = 1'b1;
					end
					if (sec_div != 10'd0)
						sec_div = sec_div - 10'd1;
					if (sec_div == 10'd0) begin
						sec_div = SECOND_RELOAD;
						if (idle_s != 16'hFFFF)
							idle_s = idle_s + 16'd1;
						if (press_s != 16'hFFFF)
							press_s = press_s + 16'd1;
					end
					if (soak_left != 16'd0) begin
						if (soak_div != 10'd0)
							soak_div = soak_div - 10'd1;
						if (soak_div == 10'd0) begin
							soak_div = SECOND_RELOAD;
							soak_left = soak_left - 16'd1;
							flag_sec = 1'b1;
						end
					end
				end
			end
			ACT_START_DISP: begin
				if (val != 32'd0) begin
					disp_left = val;
					disp_on = 1'b1;
				end
			end
			ACT_LOAD_BEEP: beep_ms = clipped;
			ACT_LOAD_MS: ms_left = clipped;
			ACT_LOAD_SOAK: soak_left = clipped;
			ACT_START_DELAY: begin
				delay_goal = clipped;
				elapsed_ms = 16'd0;
			end
			ACT_CLEAR_FLAGS: begin
				flag_on = 1'b0;
				flag_off = 1'b0;
				flag_sec = 1'b0;
			end
			ACT_CLEAR_SECS: begin
				idle_s = 16'd0;
				press_s = 16'd0;
			end
			default: ;
		endcase
		r.valve_drive = valve;
		r.dispensing = disp_on;
		r.beep_on = (beep_ms != 16'd0);
		r.key_scan_pulse = strobe;
		r.blink_on_flag = flag_on;
		r.blink_off_flag = flag_off;
		r.second_flag = flag_sec;
		r.ms_timer_left = ms_left;
		r.soak_seconds_left = soak_left;
		r.delay_done = (elapsed_ms >= delay_goal);
		r.idle_seconds = idle_s;
		r.pressure_seconds = press_s;
		return r;
	endfunction

	function automatic string diff_fields(input result_t e, input result_t a);
		string s;
		s = "";
		if (e.valve_drive != a.valve_drive)
			s = {s, $sformatf(" valve_drive exp %0d got %0d", e.valve_drive, a.valve_drive)};
		if (e.dispensing != a.dispensing)
			s = {s, $sformatf(" dispensing exp %0d got %0d", e.dispensing, a.dispensing)};
		if (e.beep_on != a.beep_on)
			s = {s, $sformatf(" beep_on exp %0d got %0d", e.beep_on, a.beep_on)};
		if (e.key_scan_pulse != a.key_scan_pulse)
			s = {s, $sformatf(" key_scan_pulse exp %0d got %0d",
				e.key_scan_pulse, a.key_scan_pulse)};
		if (e.blink_on_flag != a.blink_on_flag)
			s = {s, $sformatf(" blink_on_flag exp %0d got %0d",
				e.blink_on_flag, a.blink_on_flag)};
		if (e.blink_off_flag != a.blink_off_flag)
			s = {s, $sformatf(" blink_off_flag exp %0d got %0d",
				e.blink_off_flag, a.blink_off_flag)};
		if (e.second_flag != a.second_flag)
			s = {s, $sformatf(" second_flag exp %0d got %0d", e.second_flag, a.second_flag)};
		if (e.ms_timer_left != a.ms_timer_left)
			s = {s, $sformatf(" ms_timer_left exp %0d got %0d",
				e.ms_timer_left, a.ms_timer_left)};
		if (e.soak_seconds_left != a.soak_seconds_left)
			s = {s, $sformatf(" soak_seconds_left exp %0d got %0d",
				e.soak_seconds_left, a.soak_seconds_left)};
		if (e.delay_done != a.delay_done)
			s = {s, $sformatf(" delay_done exp %0d got %0d", e.delay_done, a.delay_done)};
		if (e.idle_seconds != a.idle_seconds)
			s = {s, $sformatf(" idle_seconds exp %0d got %0d",
				e.idle_seconds, a.idle_seconds)};
		if (e.pressure_seconds != a.pressure_seconds)
			s = {s, $sformatf(" pressure_seconds exp %0d got %0d",
				e.pressure_seconds, a.pressure_seconds)};
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_on = 1'b0;
			disp_left = 32'd0;
			boost_left = BOOST_TICKS;
			pause_cfg = PAUSE_RESET;
			pause_left = 16'd0;
			valve = VALVE_OFF;
			tick_div = SUB_MS_RELOAD;
			key_div = KEY_RELOAD;
			blink_div = BLINK_FIRST;
			sec_div = SECOND_RELOAD;
			soak_div = SECOND_RELOAD;
			beep_ms = 16'd0;
			ms_left = 16'd0;
			soak_left = 16'd0;
			elapsed_ms = 16'd0;
			delay_goal = 16'd0;
			idle_s = 16'd0;
			press_s = 16'd0;
			flag_on = 1'b0;
			flag_off = 1'b0;
			flag_sec = 1'b0;
			status_due.delete();
			err_count = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[RES_W-1:0];
				if (status_due.size() == 0) begin
					if (err_count < 10)
						$display("%0t: result item with none expected: %h", $time, m_tdata);
					err_count++;
				end else begin
					want = status_due.pop_front();
					diff = diff_fields(want, got);
					if (|m_tdata[OUT_DATA_W-1:RES_W])
						diff = {diff, $sformatf(" padding exp 0 got %h",
							m_tdata[OUT_DATA_W-1:RES_W])};
					if (diff != "") begin
						if (err_count < 10)
							$display("%0t: result mismatch:%s", $time, diff);
						err_count++;
					end
				end
			end
			if (cfg_wr_en)
				pause_cfg = cfg_wr_data;
			if (s_tvalid && s_tready)
				status_due.push_back(step_timers(action_t'(s_tuser), s_tdata));
			errors <= err_count;
			outstanding <= status_due.size();
		end
	end

endmodule

@@ bench/dispense_valve_tick_timers_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for dispense_valve_tick_timers: reset, pause register writes,
// directed and random command items with bursty sender and stalling receiver.
// Depends on dvt_pkg, dispense_valve_tick_timers and dvt_timer_checker.
module dispense_valve_tick_timers_tb;
	import dvt_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [15:0]           cfg_wr_data = 16'd0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    errors;
	int                    outstanding;
	int                    burst_left = 0;

	always #5 clk = ~clk;

	dispense_valve_tick_timers DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	dvt_timer_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	task automatic send_item(input action_t act, input logic [31:0] val);
		int gap;
		if (burst_left == 0)
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= val;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_pause(input logic [15:0] ms);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ms;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// tick_pct: share of ticks; the rest are commands with mostly small operands
	task automatic random_items(input int count, input int tick_pct);
		action_t     act;
		logic [31:0] val;
		logic [31:0] load_val;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: load_val = $urandom();
				1: load_val = $urandom_range(65534, 65537);
				2: load_val = 32'd0;
				default: load_val = $urandom_range(1, 60);
			endcase
			if ($urandom_range(0, 99) < tick_pct) begin
				act = ACT_TICK;
				val = $urandom();
			end else begin
				case ($urandom_range(1, 9))
					2: begin
						act = ACT_LOAD_BEEP;
						val = load_val;
					end
					3: begin
						act = ACT_LOAD_MS;
						val = load_val;
					end
					4: begin
						act = ACT_LOAD_SOAK;
						val = ($urandom_range(0, 9) == 0) ? load_val : $urandom_range(1, 5);
					end
					5: begin
						act = ACT_START_DELAY;
						val = load_val;
					end
					6: begin
						act = ACT_CLEAR_FLAGS;
						val = $urandom();
					end
					7: begin
						act = ACT_CLEAR_SECS;
						val = $urandom();
					end
					default: begin
						act = ACT_START_DISP;
						case ($urandom_range(0, 19))
							0: val = 32'd0;
							1: val = $urandom();
							2, 3, 4: val = $urandom_range(1, 5);
							default: val = $urandom_range(1, 120);
						endcase
					end
				endcase
			end
			send_item(act, val);
		end
	endtask

	initial begin : sink
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(100, 300)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_pause(16'd0);

		send_item(ACT_TICK, 32'hFFFF_FFFF);
		send_item(ACT_START_DISP, 32'd0);
		send_item(ACT_START_DISP, 32'hFFFF_FFFF);
		send_item(ACT_START_DISP, 32'd3);
		repeat (4) send_item(ACT_TICK, 32'd0);
		send_item(ACT_LOAD_BEEP, 32'h0001_0000);
		send_item(ACT_LOAD_BEEP, 32'd0);
		send_item(ACT_LOAD_MS, 32'hFFFF_FFFF);
		send_item(ACT_LOAD_MS, 32'd5);
		send_item(ACT_LOAD_SOAK, 32'h0001_0000);
		send_item(ACT_LOAD_SOAK, 32'd2);
		send_item(ACT_START_DELAY, 32'd70000);
		send_item(ACT_START_DELAY, 32'd0);
		send_item(ACT_START_DELAY, 32'd3);
		send_item(ACT_CLEAR_FLAGS, 32'd0);
		send_item(ACT_CLEAR_SECS, 32'hFFFF_FFFF);
		send_item(ACT_START_DISP, 32'd46);
		random_items(300, 70);

		settle();
		write_pause(16'($urandom_range(1, 30)));
		random_items(300, 70);

		// tick-heavy run through the ms prescaler and key strobe
		settle();
		write_pause(PAUSE_RESET);
		send_item(ACT_LOAD_SOAK, 32'd3);
		random_items(250, 99);

		settle();
		write_pause(16'hFFFF);
		send_item(ACT_START_DISP, 32'd2);
		random_items(30, 70);

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#15_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
